FILE: rtl/bfcbc_pkg.sv
`default_nettype none

package bfcbc_pkg;

    // Item kinds on the command channel
    localparam logic [2:0] KIND_P_WRITE     = 3'd0;
    localparam logic [2:0] KIND_S_WRITE     = 3'd1;
    localparam logic [2:0] KIND_DECRYPT     = 3'd2;
    localparam logic [2:0] KIND_ENCRYPT     = 3'd3;
    localparam logic [2:0] KIND_CHAIN_RESET = 3'd4;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned SBOX_COUNT = 4;
    localparam int unsigned SBOX_DEPTH = 256;
    localparam int unsigned TABLE_IDX_W = 10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        MODE_ENC,
        MODE_DEC,
        MODE_PASS
    } mode_t;

    // One S-box word write, steered to a bank by the top two index bits
    typedef struct packed {
        logic                   en;
        logic [TABLE_IDX_W-1:0] addr;
        logic [WORD_W-1:0]      data;
    } sbox_wr_t;

    // Read data of the four banks, box 0 at index 0
    typedef logic [SBOX_COUNT-1:0][WORD_W-1:0] sbox_rd_t;

    // F(x) = ((S0 + S1) ^ S2) + S3, sums modulo 2^32
    function automatic logic [WORD_W-1:0] feistel(sbox_rd_t s);
        logic [WORD_W-1:0] sum01;
        sum01   = s[0] + s[1];
        feistel = (sum01 ^ s[2]) + s[3];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bfcbc_parray.sv
`default_nettype none

module bfcbc_parray #(
    parameter int unsigned DEPTH = 18,
    parameter int unsigned AW    = 5
) (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [AW-1:0]                  wr_addr,
    input  wire logic [bfcbc_pkg::WORD_W-1:0]   wr_data,
    input  wire logic [AW-1:0]                  rd_addr,
    output logic      [bfcbc_pkg::WORD_W-1:0]   rd_data
);

    logic [bfcbc_pkg::WORD_W-1:0] p_reg [DEPTH];

    // Subkey words, no reset; the user must see that each entry is written before it is used, unchecked here
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            p_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = p_reg[rd_addr];

endmodule

`default_nettype wire

FILE: rtl/bfcbc_sbox.sv
`default_nettype none

module bfcbc_sbox (
    input  wire logic                           clk,
    input  wire bfcbc_pkg::sbox_wr_t            wr,
    input  wire logic [bfcbc_pkg::WORD_W-1:0]   rd_word,
    output bfcbc_pkg::sbox_rd_t                 rd_data
);

    bfcbc_pkg::sbox_rd_t rd_data_reg;

    for (genvar b = 0; b < bfcbc_pkg::SBOX_COUNT; b++)
    begin : g_bank
        logic [bfcbc_pkg::WORD_W-1:0] bank_mem [bfcbc_pkg::SBOX_DEPTH];

        // Box b looks up byte (3-b) of the word, most significant byte for box 0
        always_ff @(posedge clk)
        begin
            if (wr.en && (wr.addr[9:8] == 2'(b)))
            begin
                bank_mem[wr.addr[7:0]] <= wr.data;
            end
            rd_data_reg[b] <= bank_mem[rd_word[8*(3-b) +: 8]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/blowfish_cbc_block_cipher_unit.sv
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------------
// command   | cmd_valid/cmd_stall  | kind, table_index, write_value, block_left/right
// result    | rsp_valid/rsp_stall  | result_left, result_right
// config    | cfg_write_en         | cfg_write_data (cipher enable)
//
// A cipher block is accepted and issues the first S-box read, then takes one step per
// round (the four S-box banks answer a lookup every cycle and the round logic feeds
// the next address straight back), then one final step for output whitening and the
// CBC XOR. A decrypt while disabled skips the rounds and goes to the final step.
// Reset clears control, chain and enable; the subkey stores are not cleared. A stalled
// result holds in the output register; the next command is still taken, and its final
// step waits until the register frees.
module blowfish_cbc_block_cipher_unit #(
    parameter int unsigned ROUNDS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          cfg_write_en,
    input  wire logic          cfg_write_data,

    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire logic [2:0]    kind,
    input  wire logic [9:0]    table_index,
    input  wire logic [31:0]   write_value,
    input  wire logic [31:0]   block_left,
    input  wire logic [31:0]   block_right,

    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output logic [31:0]        result_left,
    output logic [31:0]        result_right
);

    localparam int unsigned P_DEPTH = ROUNDS + 2;
    localparam int unsigned PW      = $clog2(P_DEPTH);
    localparam int unsigned RW      = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    bfcbc_pkg::state_t state_reg, state_next;
    bfcbc_pkg::mode_t  mode_reg,  mode_next;

    logic              enable_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [PW-1:0]     kidx_reg, kidx_next;
    logic [RW-1:0]     rcnt_reg, rcnt_next;

    logic [31:0]       l_reg, l_next;
    logic [31:0]       r_reg, r_next;
    logic [31:0]       blk_l_reg, blk_l_next;
    logic [31:0]       blk_r_reg, blk_r_next;
    logic [31:0]       chain_l_reg, chain_l_next;
    logic [31:0]       chain_r_reg, chain_r_next;
    logic [31:0]       res_l_reg, res_l_next;
    logic [31:0]       res_r_reg, res_r_next;

    logic              cmd_xfer;
    logic              p_wr_en;
    logic [PW-1:0]     p_addr;
    logic [PW-1:0]     start_key;
    logic [31:0]       p_rd;
    logic [31:0]       f_out;
    logic [31:0]       new_r;
    bfcbc_pkg::sbox_wr_t s_wr;
    bfcbc_pkg::sbox_rd_t s_rd;

    bfcbc_parray #(
        .DEPTH (P_DEPTH),
        .AW    (PW)
    ) u_parray (
        .clk     (clk),
        .wr_en   (p_wr_en),
        .wr_addr (table_index[PW-1:0]),
        .wr_data (write_value),
        .rd_addr (p_addr),
        .rd_data (p_rd)
    );

    // Next round's left half addresses the banks, so the registered read data
    // lines up with l_reg in the cycle after
    bfcbc_sbox u_sbox (
        .clk     (clk),
        .wr      (s_wr),
        .rd_word (l_next),
        .rd_data (s_rd)
    );

    assign cmd_stall    = (state_reg != bfcbc_pkg::ST_IDLE);
    assign cmd_xfer     = cmd_valid && !cmd_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign result_left  = res_l_reg;
    assign result_right = res_r_reg;

    assign f_out = bfcbc_pkg::feistel(s_rd);
    assign new_r = r_reg ^ f_out;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        rsp_valid_next = rsp_valid_reg;
        kidx_next      = kidx_reg;
        rcnt_next      = rcnt_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        blk_l_next     = blk_l_reg;
        blk_r_next     = blk_r_reg;
        chain_l_next   = chain_l_reg;
        chain_r_next   = chain_r_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        p_wr_en        = 1'b0;
        s_wr           = '0;
        p_addr         = kidx_reg;
        start_key      = (kind == bfcbc_pkg::KIND_ENCRYPT) ? '0 : PW'(ROUNDS + 1);

        // Drop the result once it has been taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            bfcbc_pkg::ST_IDLE:
            begin
                p_addr = start_key;
                if (cmd_xfer)
                begin
                    case (kind)
                        bfcbc_pkg::KIND_P_WRITE:
                        begin
                            p_wr_en = (32'(table_index) < 32'(P_DEPTH));
                        end
                        bfcbc_pkg::KIND_S_WRITE:
                        begin
                            s_wr.en   = 1'b1;
                            s_wr.addr = table_index;
                            s_wr.data = write_value;
                        end
                        bfcbc_pkg::KIND_DECRYPT, bfcbc_pkg::KIND_ENCRYPT:
                        begin
                            blk_l_next = block_left;
                            blk_r_next = block_right;
                            l_next     = block_left ^ p_rd;
                            r_next     = block_right;
                            rcnt_next  = '0;
                            if (kind == bfcbc_pkg::KIND_ENCRYPT)
                            begin
                                mode_next  = bfcbc_pkg::MODE_ENC;
                                kidx_next  = start_key + PW'(1);
                                state_next = bfcbc_pkg::ST_ROUND;
                            end
                            else if (enable_reg)
                            begin
                                mode_next  = bfcbc_pkg::MODE_DEC;
                                kidx_next  = start_key - PW'(1);
                                state_next = bfcbc_pkg::ST_ROUND;
                            end
                            else
                            begin
                                mode_next  = bfcbc_pkg::MODE_PASS;
                                state_next = bfcbc_pkg::ST_FINAL;
                            end
                        end
                        bfcbc_pkg::KIND_CHAIN_RESET:
                        begin
                            chain_l_next = '0;
                            chain_r_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            bfcbc_pkg::ST_ROUND:
            begin
                // Finish this round's F, swap, and key the next left half.
                // After the last round the key is the first whitening word.
                l_next    = new_r ^ p_rd;
                r_next    = l_reg;
                rcnt_next = rcnt_reg + RW'(1);
                if (mode_reg == bfcbc_pkg::MODE_ENC)
                begin
                    kidx_next = kidx_reg + PW'(1);
                end
                else
                begin
                    kidx_next = kidx_reg - PW'(1);
                end
                if (rcnt_reg == RW'(ROUNDS - 1))
                begin
                    state_next = bfcbc_pkg::ST_FINAL;
                end
            end

            bfcbc_pkg::ST_FINAL:
            begin
                // Hold here until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = bfcbc_pkg::ST_IDLE;
                    case (mode_reg)
                        bfcbc_pkg::MODE_ENC:
                        begin
                            res_l_next = r_reg ^ p_rd;
                            res_r_next = l_reg;
                        end
                        bfcbc_pkg::MODE_DEC:
                        begin
                            res_l_next   = r_reg ^ p_rd ^ chain_l_reg;
                            res_r_next   = l_reg ^ chain_r_reg;
                            chain_l_next = blk_l_reg;
                            chain_r_next = blk_r_reg;
                        end
                        default:
                        begin
                            res_l_next = blk_l_reg;
                            res_r_next = blk_r_reg;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = bfcbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfcbc_pkg::ST_IDLE;
            mode_reg      <= bfcbc_pkg::MODE_ENC;
            rsp_valid_reg <= 1'b0;
            enable_reg    <= 1'b0;
            kidx_reg      <= '0;
            rcnt_reg      <= '0;
            chain_l_reg   <= '0;
            chain_r_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            rsp_valid_reg <= rsp_valid_next;
            kidx_reg      <= kidx_next;
            rcnt_reg      <= rcnt_next;
            chain_l_reg   <= chain_l_next;
            chain_r_reg   <= chain_r_next;
            if (cfg_write_en)
            begin
                enable_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg     <= l_next;
        r_reg     <= r_next;
        blk_l_reg <= blk_l_next;
        blk_r_reg <= blk_r_next;
        res_l_reg <= res_l_next;
        res_r_reg <= res_r_next;
    end

endmodule

`default_nettype wire

FILE: verif/blowfish_cbc_block_cipher_unit_test.sv
`default_nettype none

module blowfish_cbc_block_cipher_unit_test;

    localparam int unsigned ROUNDS  = 16;
    localparam int unsigned P_WORDS = ROUNDS + 2;
    localparam int unsigned S_WORDS = bfcbc_pkg::SBOX_COUNT * bfcbc_pkg::SBOX_DEPTH;

    // Kinds the block must swallow without a result
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    localparam int unsigned MAX_REPORTS = 10;
    // Time limit for the whole run; reaching it reports an error
    localparam int unsigned RUN_LIMIT   = 2_000_000;

    typedef struct packed {
        logic [2:0]                   kind;
        logic [9:0]                   index;
        logic [bfcbc_pkg::WORD_W-1:0] word;
        logic [bfcbc_pkg::WORD_W-1:0] left;
        logic [bfcbc_pkg::WORD_W-1:0] right;
    } cipher_cmd_t;

    typedef struct packed {
        logic [bfcbc_pkg::WORD_W-1:0] left;
        logic [bfcbc_pkg::WORD_W-1:0] right;
    } block_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_write_en   = 1'b0;
    logic               cfg_write_data = 1'b0;
    logic               cmd_valid      = 1'b0;
    logic               cmd_stall;
    logic [2:0]         kind           = bfcbc_pkg::KIND_P_WRITE;
    logic [9:0]         table_index    = '0;
    logic [31:0]        write_value    = '0;
    logic [31:0]        block_left     = '0;
    logic [31:0]        block_right    = '0;
    logic               rsp_valid;
    logic               rsp_stall      = 1'b0;
    logic [31:0]        result_left;
    logic [31:0]        result_right;

    // Shadow of the cipher: subkeys, CBC chain and the enable register
    logic [bfcbc_pkg::WORD_W-1:0]  p_words [P_WORDS];
    logic [bfcbc_pkg::WORD_W-1:0]  s_words [S_WORDS];
    logic [bfcbc_pkg::WORD_W-1:0]  chain_l = '0;
    logic [bfcbc_pkg::WORD_W-1:0]  chain_r = '0;
    logic               cipher_on = 1'b0;

    cipher_cmd_t        pending_cmds [$];
    block_t             expected_blocks [$];

    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        mismatch_count = 0;

    blowfish_cbc_block_cipher_unit #(
        .ROUNDS(ROUNDS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .kind           (kind),
        .table_index    (table_index),
        .write_value    (write_value),
        .block_left     (block_left),
        .block_right    (block_right),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result_left    (result_left),
        .result_right   (result_right)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hold reset, then release it away from the sampling edge
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Cipher prediction
    // ------------------------------------------------------------------

    // F: four S-box lookups, one per byte of x, high byte into box 0
    function automatic logic [bfcbc_pkg::WORD_W-1:0] sbox_mix(
        input logic [bfcbc_pkg::WORD_W-1:0] x);
        logic [bfcbc_pkg::WORD_W-1:0] a;
        logic [bfcbc_pkg::WORD_W-1:0] b;
        logic [bfcbc_pkg::WORD_W-1:0] c;
        logic [bfcbc_pkg::WORD_W-1:0] d;
        a = s_words[{2'd0, x[31:24]}];
        b = s_words[{2'd1, x[23:16]}];
        c = s_words[{2'd2, x[15:8]}];
        d = s_words[{2'd3, x[7:0]}];
        return ((a + b) ^ c) + d;
    endfunction

    // One Feistel round, halves swapped at the end
    function automatic void feistel_round(inout logic [bfcbc_pkg::WORD_W-1:0] l,
                                          inout logic [bfcbc_pkg::WORD_W-1:0] r,
                                          input logic [bfcbc_pkg::WORD_W-1:0] key);
        logic [bfcbc_pkg::WORD_W-1:0] t;
        l = l ^ key;
        r = r ^ sbox_mix(l);
        t = l;
        l = r;
        r = t;
    endfunction

    function automatic void encipher(inout logic [bfcbc_pkg::WORD_W-1:0] l,
                                     inout logic [bfcbc_pkg::WORD_W-1:0] r);
        logic [bfcbc_pkg::WORD_W-1:0] xl;
        logic [bfcbc_pkg::WORD_W-1:0] xr;
        xl = l;
        xr = r;
        for (int i = 0; i < ROUNDS; i++)
            feistel_round(xl, xr, p_words[i]);
        xl = xl ^ p_words[ROUNDS];
        xr = xr ^ p_words[ROUNDS + 1];
        l = xr;
        r = xl;
    endfunction

    // Same network with the subkeys taken in reverse order
    function automatic void decipher(inout logic [bfcbc_pkg::WORD_W-1:0] l,
                                     inout logic [bfcbc_pkg::WORD_W-1:0] r);
        logic [bfcbc_pkg::WORD_W-1:0] xl;
        logic [bfcbc_pkg::WORD_W-1:0] xr;
        xl = l;
        xr = r;
        for (int i = ROUNDS + 1; i > 1; i--)
            feistel_round(xl, xr, p_words[i]);
        xl = xl ^ p_words[1];
        xr = xr ^ p_words[0];
        l = xr;
        r = xl;
    endfunction

    // Apply one accepted command to the shadow state; queue its block if it
    // produces one
    function automatic void absorb_cmd(input cipher_cmd_t c);
        logic [bfcbc_pkg::WORD_W-1:0] l;
        logic [bfcbc_pkg::WORD_W-1:0] r;
        l = c.left;
        r = c.right;
        case (c.kind)
            bfcbc_pkg::KIND_P_WRITE:
            begin
                // Out-of-range P indexes are dropped by the block
                if (c.index < P_WORDS)
                    p_words[c.index] = c.word;
            end
            bfcbc_pkg::KIND_S_WRITE:
            begin
                s_words[c.index] = c.word;
            end
            bfcbc_pkg::KIND_DECRYPT:
            begin
                // Disabled: pass the block through and leave the chain alone
                if (cipher_on)
                begin
                    decipher(l, r);
                    l = l ^ chain_l;
                    r = r ^ chain_r;
                    chain_l = c.left;
                    chain_r = c.right;
                end
                expected_blocks.push_back('{left: l, right: r});
            end
            bfcbc_pkg::KIND_ENCRYPT:
            begin
                // Raw ECB, runs whether or not the cipher is enabled
                encipher(l, r);
                expected_blocks.push_back('{left: l, right: r});
            end
            bfcbc_pkg::KIND_CHAIN_RESET:
            begin
                chain_l = '0;
                chain_r = '0;
            end
            default:
            begin
                // Spare kinds: no effect, no result
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Command driver: one transfer per accepted edge, random idle gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_cmd
        logic        taken;
        cipher_cmd_t next_cmd;
        if (rst_n)
        begin
            taken = cmd_valid && !cmd_stall;
            if (taken)
                absorb_cmd('{kind: kind, index: table_index, word: write_value,
                             left: block_left, right: block_right});
            // Hold a stalled command as it is; only refill once the slot is free
            if (!cmd_valid || taken)
            begin
                if (pending_cmds.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_cmd = pending_cmds.pop_front();
                    kind        <= next_cmd.kind;
                    table_index <= next_cmd.index;
                    write_value <= next_cmd.word;
                    block_left  <= next_cmd.left;
                    block_right <= next_cmd.right;
                    cmd_valid   <= 1'b1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest expected block
    // ------------------------------------------------------------------
    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    always @(posedge clk)
    begin : watch_result
        block_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h %h",
                                              result_left, result_right));
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (result_left !== want.left)
                        report_mismatch($sformatf("result_left expected %h, got %h",
                                                  want.left, result_left));
                    if (result_right !== want.right)
                        report_mismatch($sformatf("result_right expected %h, got %h",
                                                  want.right, result_right));
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Mostly random words, with the all-zero and all-one extremes mixed in
    function automatic logic [bfcbc_pkg::WORD_W-1:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return $urandom();
    endfunction

    function automatic logic [9:0] rand_index();
        return 10'($urandom_range(0, S_WORDS - 1));
    endfunction

    function automatic void enqueue(input logic [2:0] k, input logic [9:0] idx,
                                    input logic [bfcbc_pkg::WORD_W-1:0] wv,
                                    input logic [bfcbc_pkg::WORD_W-1:0] bl,
                                    input logic [bfcbc_pkg::WORD_W-1:0] br);
        pending_cmds.push_back('{kind: k, index: idx, word: wv, left: bl, right: br});
    endfunction

    // Block commands carry junk in the fields they do not use
    function automatic void enqueue_block(input logic [2:0] k,
                                          input logic [bfcbc_pkg::WORD_W-1:0] bl,
                                          input logic [bfcbc_pkg::WORD_W-1:0] br);
        enqueue(k, rand_index(), rand_word(), bl, br);
    endfunction

    // Random traffic: mostly CBC messages (chain reset plus a few blocks) and
    // ECB blocks, with some rekeying, stray P indexes and spare kinds
    function automatic void queue_random_traffic(input int unsigned count);
        int unsigned done_items;
        int unsigned pick;
        int unsigned msg_len;
        done_items = 0;
        while (done_items < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                msg_len = $urandom_range(1, 6);
                enqueue_block(bfcbc_pkg::KIND_CHAIN_RESET, rand_word(), rand_word());
                repeat (msg_len)
                    enqueue_block(bfcbc_pkg::KIND_DECRYPT, rand_word(), rand_word());
                done_items += msg_len + 1;
            end
            else if (pick < 65)
            begin
                enqueue_block(bfcbc_pkg::KIND_ENCRYPT, rand_word(), rand_word());
                done_items++;
            end
            else if (pick < 78)
            begin
                enqueue_block(bfcbc_pkg::KIND_DECRYPT, rand_word(), rand_word());
                done_items++;
            end
            else if (pick < 86)
            begin
                enqueue(bfcbc_pkg::KIND_S_WRITE, rand_index(), rand_word(), rand_word(),
                        rand_word());
                done_items++;
            end
            else if (pick < 91)
            begin
                enqueue(bfcbc_pkg::KIND_P_WRITE, 10'($urandom_range(0, P_WORDS - 1)),
                        rand_word(), rand_word(), rand_word());
                done_items++;
            end
            else if (pick < 94)
            begin
                // Dropped by the block, so not counted
                enqueue(bfcbc_pkg::KIND_P_WRITE, 10'($urandom_range(P_WORDS, S_WORDS - 1)),
                        rand_word(), rand_word(), rand_word());
            end
            else if (pick < 97)
            begin
                enqueue(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), rand_index(),
                        rand_word(), rand_word(), rand_word());
            end
            else
            begin
                enqueue_block(bfcbc_pkg::KIND_CHAIN_RESET, rand_word(), rand_word());
                done_items++;
            end
        end
    endfunction

    // Wait until every command is taken and every block is back, then give a
    // silent command time to finish inside the block
    task automatic settle();
        while (pending_cmds.size() != 0 || cmd_valid || expected_blocks.size() != 0)
            @(negedge clk);
        repeat (ROUNDS + 4) @(negedge clk);
    endtask

    task automatic set_cipher_enable(input logic on);
        settle();
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= on;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        cipher_on = on;
    endtask

    initial
    begin : stimulus
        wait (rst_n);

        // Phase 1: sender mostly busy, receiver mostly stalled
        send_idle_pct = 17;
        recv_idle_pct = 83;
        set_cipher_enable(1'b0);

        // Disabled decrypt needs no subkeys: pass-through at the extremes
        enqueue_block(bfcbc_pkg::KIND_DECRYPT, '0, '0);
        enqueue_block(bfcbc_pkg::KIND_DECRYPT, '1, '1);
        enqueue_block(bfcbc_pkg::KIND_DECRYPT, rand_word(), rand_word());
        enqueue_block(bfcbc_pkg::KIND_CHAIN_RESET, '1, '1);
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            enqueue(3'(k), '1, '1, '1, '1);
        // Out-of-range P writes must leave the subkeys untouched
        enqueue(bfcbc_pkg::KIND_P_WRITE, 10'(P_WORDS), '1, '0, '0);
        enqueue(bfcbc_pkg::KIND_P_WRITE, '1, '1, '0, '0);

        // Load every subkey before anything reads one
        for (int i = 0; i < P_WORDS; i++)
            enqueue(bfcbc_pkg::KIND_P_WRITE, 10'(i),
                    (i == 0) ? '0 : (i == 1) ? '1 : $urandom(),
                    rand_word(), rand_word());
        for (int i = 0; i < S_WORDS; i++)
            enqueue(bfcbc_pkg::KIND_S_WRITE, 10'(i),
                    (i == 0) ? '0 : (i == S_WORDS - 1) ? '1 : $urandom(),
                    rand_word(), rand_word());

        // Encrypt runs even while disabled
        enqueue_block(bfcbc_pkg::KIND_ENCRYPT, '0, '0);
        enqueue_block(bfcbc_pkg::KIND_ENCRYPT, '1, '1);

        set_cipher_enable(1'b1);

        // CBC chain from zero, chaining on, chain cleared mid-stream
        enqueue_block(bfcbc_pkg::KIND_DECRYPT, '0, '0);
        enqueue_block(bfcbc_pkg::KIND_DECRYPT, '1, '1);
        enqueue_block(bfcbc_pkg::KIND_DECRYPT, rand_word(), rand_word());
        enqueue_block(bfcbc_pkg::KIND_CHAIN_RESET, '0, '0);
        enqueue_block(bfcbc_pkg::KIND_DECRYPT, '1, '0);
        enqueue_block(bfcbc_pkg::KIND_ENCRYPT, rand_word(), rand_word());
        // Rekey the last P word and one S word, then use them
        enqueue(bfcbc_pkg::KIND_P_WRITE, 10'(P_WORDS - 1), $urandom(), '0, '0);
        enqueue(bfcbc_pkg::KIND_S_WRITE, 10'(2 * bfcbc_pkg::SBOX_DEPTH), $urandom(),
                '0, '0);
        enqueue_block(bfcbc_pkg::KIND_ENCRYPT, '1, '1);
        enqueue_block(bfcbc_pkg::KIND_DECRYPT, '0, '1);

        queue_random_traffic(210);

        // Phase 2: sender mostly idle, receiver rarely stalls
        settle();
        send_idle_pct = 83;
        recv_idle_pct = 17;
        set_cipher_enable(1'b0);
        queue_random_traffic(70);
        set_cipher_enable(1'b1);
        queue_random_traffic(130);

        // Phase 3: back-to-back, no idling on either side
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_traffic(190);

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
